### src/erps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erps_pkg
// Shared constants, widths and helpers of the expanding ring pixel shader.
// ----------------------------------------------------------------------------
package erps_pkg;

  // default panel and ring setup
  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 64;
  localparam int RING_COUNT_DEF   = 3;

  // field widths
  localparam int TIME_W  = 16;
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;
  localparam int DUR_W   = 16;

  // Q16 constants
  localparam longint Q_ONE        = 65536;
  localparam longint START_STEP_Q = 5243;
  localparam longint HUE_BASE_Q   = 38011;
  localparam longint HUE_STEP_Q   = 7864;
  localparam longint SAT_Q        = 55706;
  localparam longint SAT_C_Q      = Q_ONE - SAT_Q;
  localparam longint THICK_BASE_Q = 163840;

  // floor(n/3) as (n * M) >> 21, exact for n below 2^21
  localparam longint RECIP3_M = 699051;

  // datapath widths
  localparam int ABS_W   = 8;          // |2x+1-W|, at most 255
  localparam int SQ_W    = 17;         // sum of two squares
  localparam int SQRT_IN_W  = 48;      // sum of squares shifted up by 30, padded
  localparam int DIST_W  = 24;         // Q16 distance
  localparam int THICK_W = 19;
  localparam int FRAC_W  = 16;

  // APB register map
  localparam int        APB_ADDR_W = 3;
  localparam logic      REG_DURATION = 1'b0;   // word index bit
  localparam logic [15:0] DURATION_RST = 16'd2000;

  // hue sectors
  localparam logic [2:0] SECT_RED_YEL = 3'd0;
  localparam logic [2:0] SECT_YEL_GRN = 3'd1;
  localparam logic [2:0] SECT_GRN_CYN = 3'd2;
  localparam logic [2:0] SECT_CYN_BLU = 3'd3;
  localparam logic [2:0] SECT_BLU_MAG = 3'd4;

  // floored integer square root, elaboration use only
  function automatic longint unsigned isqrt_const(input longint unsigned n);
    longint unsigned res;
    longint unsigned bits;
    longint unsigned rem;
    res  = 0;
    rem  = n;
    bits = 64'd1 << 62;
    while (bits > rem) bits = bits >> 2;
    while (bits != 0) begin
      if (rem >= res + bits) begin
        rem = rem - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  // Q16 fraction to byte, rounding half up
  function automatic logic [7:0] to_byte(input logic [15:0] x);
    logic [24:0] s;
    s = {9'b0, x} * 25'd255 + 25'd32768;
    return s[23:16];
  endfunction

endpackage

### src/erps_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erps_div
// Pipelined restoring divider: quo = floor(num * 2^Q_W / den), num < den.
// ----------------------------------------------------------------------------
module erps_div #(
  parameter int DEN_W  = 16,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  logic [DEN_W-1:0]  rem_s  [Q_W+1];
  logic [DEN_W-1:0]  den_s  [Q_W+1];
  logic [Q_W-1:0]    quo_s  [Q_W+1];
  logic [SIDE_W-1:0] side_s [Q_W+1];

  assign rem_s[0]  = num;
  assign den_s[0]  = den;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_in;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W:0]    r2;
    logic              ge;
    logic [DEN_W-1:0]  rem_r;
    logic [DEN_W-1:0]  den_r;
    logic [Q_W-1:0]    quo_r;
    logic [SIDE_W-1:0] side_r;

    assign r2 = {rem_s[i], 1'b0};
    assign ge = (r2 >= {1'b0, den_s[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? DEN_W'(r2 - {1'b0, den_s[i]}) : r2[DEN_W-1:0];
        den_r  <= den_s[i];
        quo_r  <= {quo_s[i][Q_W-2:0], ge};
        side_r <= side_s[i];
      end
    end

    assign rem_s[i+1]  = rem_r;
    assign den_s[i+1]  = den_r;
    assign quo_s[i+1]  = quo_r;
    assign side_s[i+1] = side_r;
  end

  assign quo      = quo_s[Q_W];
  assign side_out = side_s[Q_W];

endmodule

### src/erps_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erps_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module erps_sqrt #(
  parameter int IN_W   = 48,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   n,
  input  logic [SIDE_W-1:0] side_in,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W-1:0]  rem_s  [ROOT_W+1];
  logic [ROOT_W-1:0] root_s [ROOT_W+1];
  logic [IN_W-1:0]   nsh_s  [ROOT_W+1];
  logic [SIDE_W-1:0] side_s [ROOT_W+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign nsh_s[0]  = n;
  assign side_s[0] = side_in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W-1:0]  rem_r;
    logic [ROOT_W-1:0] root_r;
    logic [IN_W-1:0]   nsh_r;
    logic [SIDE_W-1:0] side_r;

    assign rem2  = {rem_s[i], nsh_s[i][IN_W-1:IN_W-2]};
    assign trial = {2'b00, root_s[i], 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
        root_r <= {root_s[i][ROOT_W-2:0], ge};
        nsh_r  <= {nsh_s[i][IN_W-3:0], 2'b00};
        side_r <= side_s[i];
      end
    end

    assign rem_s[i+1]  = rem_r;
    assign root_s[i+1] = root_r;
    assign nsh_s[i+1]  = nsh_r;
    assign side_s[i+1] = side_r;
  end

  assign root     = root_s[ROOT_W];
  assign side_out = side_s[ROOT_W];

endmodule

### src/expanding_ring_pixel_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expanding_ring_pixel_shader
// Per-pixel colour of an expanding multi-ring boot animation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel item: time_ms, x, y.
//   Output channel (out_valid/out_ready) returns red, green, blue, running.
//   APB port holds the animation length in ms at address 0 (reset 2000,
//   0 disables).
// Throughput: one item per clock. Every stage advances together; the
//   whole pipe holds only while the output register is full and not taken,
//   so in_ready = !out_valid || out_ready.
// Depth: 68 register stages, set mainly by the 16-stage progress divider,
//   the 24-stage distance square root, and the per-ring lane with its own
//   16-stage band divider.
// Reset: clears all stage valid bits and loads the default duration.
//   Payload registers are not reset.
// Stall: when out_ready is low with out_valid high, nothing moves and
//   no item is dropped or repeated.
// ----------------------------------------------------------------------------
module expanding_ring_pixel_shader #(
  parameter int PANEL_WIDTH  = erps_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = erps_pkg::PANEL_HEIGHT_DEF,
  parameter int RING_COUNT   = erps_pkg::RING_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // pixel items in
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [erps_pkg::TIME_W-1:0]   in_time_ms,
  input  logic [erps_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [erps_pkg::COORD_W-1:0]  in_pixel_y,
  // colour items out
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [erps_pkg::COLOR_W-1:0]  out_red,
  output logic [erps_pkg::COLOR_W-1:0]  out_green,
  output logic [erps_pkg::COLOR_W-1:0]  out_blue,
  output logic                          out_running,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [erps_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int FW     = erps_pkg::FRAC_W;
  localparam int DW     = erps_pkg::DIST_W;
  localparam int TW     = erps_pkg::THICK_W;
  localparam int ROOT_W = erps_pkg::SQRT_IN_W / 2;

  // stage count: input reg, progress divider, squares, sqrt,
  // five lane stages, band divider, four lane stages, output reg
  localparam int LAT = 1 + FW + 1 + ROOT_W + 5 + FW + 4 + 1;

  // half-diagonal in Q16
  localparam longint unsigned DIAG2 =
    longint'(PANEL_WIDTH) * PANEL_WIDTH + longint'(PANEL_HEIGHT) * PANEL_HEIGHT;
  localparam logic [DW-1:0] MAX_R = DW'(erps_pkg::isqrt_const(DIAG2 << 30));

  localparam int SUM_W = $clog2(RING_COUNT * 255 + 1);

  // ------------------------------------------------------------------
  // Config register
  // ------------------------------------------------------------------
  logic [erps_pkg::DUR_W-1:0] dur_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == erps_pkg::REG_DURATION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= erps_pkg::DURATION_RST;
    end else if (cfg_wr) begin
      dur_r <= pwdata[erps_pkg::DUR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == erps_pkg::REG_DURATION) ? {16'b0, dur_r} : 32'b0;

  // ------------------------------------------------------------------
  // Pipe control: one enable for all stages
  // ------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] act_r;
  logic           act_nxt;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];
  assign act_nxt   = (dur_r != '0) && (in_time_ms < dur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // animation active flag rides alongside
  always_ff @(posedge clk) begin
    if (en) begin
      act_r <= {act_r[LAT-2:0], act_nxt};
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: offsets from the panel centre, in half pixels
  // ------------------------------------------------------------------
  logic signed [9:0]          sx, sy;
  logic [erps_pkg::ABS_W-1:0] ax_nxt, ay_nxt;
  logic [erps_pkg::ABS_W-1:0] s1_ax_r, s1_ay_r;
  logic [erps_pkg::TIME_W-1:0] s1_time_r;
  logic [erps_pkg::DUR_W-1:0]  s1_dur_r;

  assign sx = $signed({3'b000, in_pixel_x, 1'b1}) - $signed(10'(PANEL_WIDTH));
  assign sy = $signed({3'b000, in_pixel_y, 1'b1}) - $signed(10'(PANEL_HEIGHT));
  assign ax_nxt = sx[9] ? 8'(10'(-sx)) : sx[7:0];
  assign ay_nxt = sy[9] ? 8'(10'(-sy)) : sy[7:0];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_time_r <= in_time_ms;
      s1_dur_r  <= dur_r;
      s1_ax_r   <= ax_nxt;
      s1_ay_r   <= ay_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Progress u = floor(time * 2^16 / duration)
  // ------------------------------------------------------------------
  logic [FW-1:0] u_q;
  logic [15:0]   u_side;

  erps_div #(
    .DEN_W  (erps_pkg::DUR_W),
    .Q_W    (FW),
    .SIDE_W (16)
  ) u_div_prog (
    .clk      (clk),
    .en       (en),
    .num      (s1_time_r),
    .den      (s1_dur_r),
    .side_in  ({s1_ax_r, s1_ay_r}),
    .quo      (u_q),
    .side_out (u_side)
  );

  // ------------------------------------------------------------------
  // Squared distance, then distance in Q16 via the sqrt pipe
  // ------------------------------------------------------------------
  logic [erps_pkg::SQ_W-1:0] s2_sq_r;
  logic [FW-1:0]             s2_u_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq_r <= {9'b0, u_side[15:8]} * {9'b0, u_side[15:8]}
               + {9'b0, u_side[7:0]} * {9'b0, u_side[7:0]};
      s2_u_r  <= u_q;
    end
  end

  logic [DW-1:0] pix_dist;
  logic [FW-1:0] sq_u;

  erps_sqrt #(
    .IN_W   (erps_pkg::SQRT_IN_W),
    .SIDE_W (FW)
  ) u_sqrt_dist (
    .clk      (clk),
    .en       (en),
    .n        ({1'b0, s2_sq_r, 30'b0}),
    .side_in  (s2_u_r),
    .root     (pix_dist),
    .side_out (sq_u)
  );

  // ------------------------------------------------------------------
  // Ring lanes, one per ring, all in lockstep
  // ------------------------------------------------------------------
  logic [7:0] ln_red [RING_COUNT];
  logic [7:0] ln_grn [RING_COUNT];
  logic [7:0] ln_blu [RING_COUNT];

  for (genvar r = 0; r < RING_COUNT; r++) begin : g_ring
    localparam logic [17:0] START_R = 18'(erps_pkg::START_STEP_Q * r);
    localparam logic [15:0] HUE_R   =
      16'((erps_pkg::HUE_BASE_Q + erps_pkg::HUE_STEP_Q * r) % erps_pkg::Q_ONE);

    // L1: ring's own progress numerator
    logic [17:0]   num_nxt;
    logic [15:0]   l1_num_r;
    logic          l1_pos_r;
    logic [DW-1:0] l1_dist_r;

    assign num_nxt = {2'b00, sq_u} - START_R;

    always_ff @(posedge clk) begin
      if (en) begin
        l1_num_r  <= num_nxt[15:0];
        l1_pos_r  <= !num_nxt[17] && (num_nxt != '0);
        l1_dist_r <= pix_dist;
      end
    end

    // L2: times 4/3 by reciprocal
    logic [37:0]   l2_prod_r;
    logic          l2_pos_r;
    logic [DW-1:0] l2_dist_r;

    always_ff @(posedge clk) begin
      if (en) begin
        l2_prod_r <= {20'b0, l1_num_r, 2'b00} * 38'(erps_pkg::RECIP3_M);
        l2_pos_r  <= l1_pos_r;
        l2_dist_r <= l1_dist_r;
      end
    end

    // L3: ring progress w, live only for 0 < w < 1
    logic [16:0]   w17;
    logic [FW-1:0] l3_w_r;
    logic          l3_ok_r;
    logic [DW-1:0] l3_dist_r;

    assign w17 = l2_prod_r[37:21];

    always_ff @(posedge clk) begin
      if (en) begin
        l3_w_r    <= w17[15:0];
        l3_ok_r   <= l2_pos_r && !w17[16] && (w17[15:0] != '0);
        l3_dist_r <= l2_dist_r;
      end
    end

    // L4: radius, thickness, fade, hue
    logic [39:0]   rad_prod;
    logic [15:0]   om;
    logic [31:0]   om_sq;
    logic [DW-1:0] l4_rad_r;
    logic [TW-1:0] l4_thick_r;
    logic [FW-1:0] l4_fade_r;
    logic [FW-1:0] l4_hue_r;
    logic          l4_ok_r;
    logic [DW-1:0] l4_dist_r;

    assign rad_prod = {24'b0, l3_w_r} * {16'b0, MAX_R};
    assign om       = 16'(17'h10000 - {1'b0, l3_w_r});
    assign om_sq    = {16'b0, om} * {16'b0, om};

    always_ff @(posedge clk) begin
      if (en) begin
        l4_rad_r   <= rad_prod[39:16];
        l4_thick_r <= TW'(erps_pkg::THICK_BASE_Q) + {2'b0, l3_w_r, 1'b0}
                    + {3'b0, l3_w_r};
        l4_fade_r  <= om_sq[31:16];
        l4_hue_r   <= HUE_R - {2'b00, l3_w_r[15:2]};
        l4_ok_r    <= l3_ok_r;
        l4_dist_r  <= l3_dist_r;
      end
    end

    // L5: distance from the ring line, band check
    logic signed [DW:0] diff;
    logic [DW-1:0]      dabs;
    logic [TW-1:0]      l5_d_r;
    logic [TW-1:0]      l5_thick_r;
    logic               l5_on_r;
    logic [FW-1:0]      l5_fade_r;
    logic [FW-1:0]      l5_hue_r;

    assign diff = $signed({1'b0, l4_dist_r}) - $signed({1'b0, l4_rad_r});
    assign dabs = diff[DW] ? DW'(-diff) : diff[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        l5_d_r     <= dabs[TW-1:0];
        l5_thick_r <= l4_thick_r;
        l5_on_r    <= l4_ok_r && (dabs < {5'b0, l4_thick_r});
        l5_fade_r  <= l4_fade_r;
        l5_hue_r   <= l4_hue_r;
      end
    end

    // band fraction |d| / thickness in Q16
    logic [FW-1:0]   bq;
    logic [2*FW:0]   bside;

    erps_div #(
      .DEN_W  (TW),
      .Q_W    (FW),
      .SIDE_W (2 * FW + 1)
    ) u_div_band (
      .clk      (clk),
      .en       (en),
      .num      (l5_d_r),
      .den      (l5_thick_r),
      .side_in  ({l5_on_r, l5_fade_r, l5_hue_r}),
      .quo      (bq),
      .side_out (bside)
    );

    // L6: value v = a * fade, hue sector
    logic [16:0]   a;
    logic [32:0]   v_prod;
    logic [18:0]   hh;
    logic [FW-1:0] l6_v_r;
    logic [2:0]    l6_sect_r;
    logic [FW-1:0] l6_f_r;
    logic          l6_on_r;

    assign a      = 17'h10000 - {1'b0, bq};
    assign v_prod = {16'b0, a} * {17'b0, bside[2*FW-1:FW]};
    assign hh     = {3'b0, bside[FW-1:0]} * 19'd6;

    always_ff @(posedge clk) begin
      if (en) begin
        l6_v_r    <= v_prod[31:16];
        l6_sect_r <= hh[18:16];
        l6_f_r    <= hh[15:0];
        l6_on_r   <= bside[2*FW];
      end
    end

    // L7: p and the saturation terms for q and t
    logic [29:0] p_prod;
    logic [31:0] s1_prod;
    logic [32:0] s2_prod;
    logic [FW-1:0] l7_v_r, l7_p_r;
    logic [16:0]   l7_s1c_r, l7_s2c_r;
    logic [2:0]    l7_sect_r;
    logic          l7_on_r;

    assign p_prod  = {14'b0, l6_v_r} * 30'(erps_pkg::SAT_C_Q);
    assign s1_prod = {16'b0, l6_f_r} * 32'(erps_pkg::SAT_Q);
    assign s2_prod = {16'b0, 17'h10000 - {1'b0, l6_f_r}} * 33'(erps_pkg::SAT_Q);

    always_ff @(posedge clk) begin
      if (en) begin
        l7_v_r    <= l6_v_r;
        l7_p_r    <= {2'b00, p_prod[29:16]};
        l7_s1c_r  <= 17'h10000 - {1'b0, s1_prod[31:16]};
        l7_s2c_r  <= 17'h10000 - {1'b0, s2_prod[31:16]};
        l7_sect_r <= l6_sect_r;
        l7_on_r   <= l6_on_r;
      end
    end

    // L8: q and t
    logic [32:0] q_prod, t_prod;
    logic [FW-1:0] l8_v_r, l8_p_r, l8_q_r, l8_t_r;
    logic [2:0]    l8_sect_r;
    logic          l8_on_r;

    assign q_prod = {17'b0, l7_v_r} * {16'b0, l7_s1c_r};
    assign t_prod = {17'b0, l7_v_r} * {16'b0, l7_s2c_r};

    always_ff @(posedge clk) begin
      if (en) begin
        l8_v_r    <= l7_v_r;
        l8_p_r    <= l7_p_r;
        l8_q_r    <= q_prod[31:16];
        l8_t_r    <= t_prod[31:16];
        l8_sect_r <= l7_sect_r;
        l8_on_r   <= l7_on_r;
      end
    end

    // L9: sector select and bytes; dark ring adds nothing
    logic [FW-1:0] rc, gc, bc;

    always_comb begin
      case (l8_sect_r)
        erps_pkg::SECT_RED_YEL: begin rc = l8_v_r; gc = l8_t_r; bc = l8_p_r; end
        erps_pkg::SECT_YEL_GRN: begin rc = l8_q_r; gc = l8_v_r; bc = l8_p_r; end
        erps_pkg::SECT_GRN_CYN: begin rc = l8_p_r; gc = l8_v_r; bc = l8_t_r; end
        erps_pkg::SECT_CYN_BLU: begin rc = l8_p_r; gc = l8_q_r; bc = l8_v_r; end
        erps_pkg::SECT_BLU_MAG: begin rc = l8_t_r; gc = l8_p_r; bc = l8_v_r; end
        default:                begin rc = l8_v_r; gc = l8_p_r; bc = l8_q_r; end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ln_red[r] <= l8_on_r ? erps_pkg::to_byte(rc) : 8'd0;
        ln_grn[r] <= l8_on_r ? erps_pkg::to_byte(gc) : 8'd0;
        ln_blu[r] <= l8_on_r ? erps_pkg::to_byte(bc) : 8'd0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Output: ring sum per channel, saturated; black once the run is over
  // ------------------------------------------------------------------
  logic [SUM_W-1:0] sum_red, sum_grn, sum_blu;
  logic [7:0]       red_r, grn_r, blu_r;

  always_comb begin
    sum_red = '0;
    sum_grn = '0;
    sum_blu = '0;
    for (int i = 0; i < RING_COUNT; i++) begin
      sum_red = sum_red + SUM_W'(ln_red[i]);
      sum_grn = sum_grn + SUM_W'(ln_grn[i]);
      sum_blu = sum_blu + SUM_W'(ln_blu[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r <= !act_r[LAT-2] ? 8'd0 : (sum_red > SUM_W'(255)) ? 8'hFF : sum_red[7:0];
      grn_r <= !act_r[LAT-2] ? 8'd0 : (sum_grn > SUM_W'(255)) ? 8'hFF : sum_grn[7:0];
      blu_r <= !act_r[LAT-2] ? 8'd0 : (sum_blu > SUM_W'(255)) ? 8'hFF : sum_blu[7:0];
    end
  end

  assign out_red     = red_r;
  assign out_green   = grn_r;
  assign out_blue    = blu_r;
  assign out_running = act_r[LAT-1];

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the expanding ring pixel shader.
// A Q16 color predictor in the bench computes each pixel's expected color.
// Pixel items go in with random gaps and colors come out under random
// back-pressure. The animation length is reprogrammed over APB between phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int PIPE_LAT  = 68;
  localparam int MAX_CYC   = 400000;
  localparam logic [2:0] ADDR_DURATION = 3'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       running;
  } pixel_color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [erps_pkg::TIME_W-1:0] in_time_ms = '0;
  logic [erps_pkg::COORD_W-1:0] in_pixel_x = '0;
  logic [erps_pkg::COORD_W-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic out_running;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  expanding_ring_pixel_shader dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_time_ms(in_time_ms),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_ready(out_ready), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_running(out_running),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the register
  logic [15:0] duration_q = erps_pkg::DURATION_RST;
  pixel_color_t expected_colors[$];
  int errors = 0;
  int cycles = 0;
  // idle control: percent chance of a gap on each side, 0 for a clean stretch
  int send_gap_pct = 15;
  int recv_gap_pct = 15;
  int hold_cycles = 0;

  // floored integer square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned q16_byte(input longint x);
    if (x < 0) x = 0;
    if (x > 65536) x = 65536;
    return (x * 255 + 32768) >> 16;
  endfunction

  function automatic pixel_color_t shade_pixel(input logic [15:0] t,
                                               input logic [5:0] x,
                                               input logic [5:0] y);
    pixel_color_t c;
    longint u, max_r, dx, dy, pdist, num, w, radius, thick, om, fade, hue;
    longint d, a, v, hh, sector, f, p, q, tt, r, g, b;
    longint unsigned acc[3];
    c = '0;
    acc[0] = 0; acc[1] = 0; acc[2] = 0;
    if (duration_q == 0 || t >= duration_q) return c;
    u = (longint'(t) << 16) / longint'(duration_q);
    max_r = root_floor(64'(64 * 64 + 64 * 64) << 30);
    dx = (2 * longint'(x) + 1 - 64) * 32768;
    dy = (2 * longint'(y) + 1 - 64) * 32768;
    pdist = root_floor(dx * dx + dy * dy);
    for (int ring = 0; ring < 3; ring++) begin
      num = u - 5243 * ring;
      if (num <= 0) continue;
      w = (num * 4) / 3;
      if (w <= 0 || w >= 65536) continue;
      radius = (w * max_r) >>> 16;
      thick = 163840 + 3 * w;
      om = 65536 - w;
      fade = (om * om) >>> 16;
      hue = 38011 + 7864 * ring - (w >>> 2);
      d = pdist - radius;
      if (d < 0) d = -d;
      a = 65536 - (d * 65536) / thick;
      if (a <= 0) continue;
      v = (a * fade) >>> 16;
      hh = (hue & 64'hFFFF) * 6;
      sector = hh >>> 16;
      f = hh & 64'hFFFF;
      p = (v * (65536 - 55706)) >>> 16;
      q = (v * (65536 - ((55706 * f) >>> 16))) >>> 16;
      tt = (v * (65536 - ((55706 * (65536 - f)) >>> 16))) >>> 16;
      case (sector)
        0: begin r = v; g = tt; b = p; end
        1: begin r = q; g = v; b = p; end
        2: begin r = p; g = v; b = tt; end
        3: begin r = p; g = q; b = v; end
        4: begin r = tt; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
      acc[0] += q16_byte(r);
      acc[1] += q16_byte(g);
      acc[2] += q16_byte(b);
      for (int ch = 0; ch < 3; ch++) if (acc[ch] > 255) acc[ch] = 255;
    end
    c.red = acc[0][7:0];
    c.green = acc[1][7:0];
    c.blue = acc[2][7:0];
    c.running = 1'b1;
    return c;
  endfunction

  // one pixel item; prediction is taken at accept time.
  // valid drops only in a gap, so back-to-back items keep it high
  task automatic send_pixel(input logic [15:0] t, input logic [5:0] x,
                            input logic [5:0] y);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_time_ms <= t;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_colors.push_back(shade_pixel(t, x, y));
    @(negedge clk);
  endtask

  // wait for the pipe to drain, then write the animation length over APB
  task automatic write_duration(input logic [15:0] val);
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_DURATION; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    duration_q = val;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // receiver: random stalls, one long hold, and the check
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    pixel_color_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $error("color item with nothing expected");
        errors++;
      end else begin
        exp_c = expected_colors.pop_front();
        if (out_red !== exp_c.red) begin
          $error("red expected %0d actual %0d", exp_c.red, out_red); errors++;
        end
        if (out_green !== exp_c.green) begin
          $error("green expected %0d actual %0d", exp_c.green, out_green); errors++;
        end
        if (out_blue !== exp_c.blue) begin
          $error("blue expected %0d actual %0d", exp_c.blue, out_blue); errors++;
        end
        if (out_running !== exp_c.running) begin
          $error("running expected %0d actual %0d", exp_c.running, out_running);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly live animation times; some past the end
  task automatic random_pixels(input int n);
    logic [15:0] t;
    for (int i = 0; i < n; i++) begin
      if (duration_q != 0 && $urandom_range(9) < 8)
        t = 16'($urandom_range(duration_q - 1));
      else
        t = 16'($urandom);
      send_pixel(t, 6'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_directed;
    // corners, center, start, ring edges, end, just before end
    send_pixel(16'd0, 6'd0, 6'd0);
    send_pixel(16'd0, 6'd63, 6'd63);
    send_pixel(16'd500, 6'd31, 6'd32);
    send_pixel(16'd1000, 6'd0, 6'd63);
    send_pixel(16'd1000, 6'd63, 6'd0);
    send_pixel(16'd1499, 6'd16, 6'd16);
    send_pixel(16'd1999, 6'd32, 6'd31);
    send_pixel(16'd2000, 6'd10, 6'd10);
    send_pixel(16'hFFFF, 6'd63, 6'd63);
    send_pixel(16'd200, 6'd40, 6'd32);
    send_pixel(16'd800, 6'd50, 6'd20);
    for (int k = 0; k < 8; k++) send_pixel(16'(250 * k + 37), 6'(8 * k), 6'(63 - 8 * k));
  endtask

  task automatic test_duration_extremes;
    write_duration(16'd0);      // disabled: always black
    send_pixel(16'd0, 6'd32, 6'd32);
    send_pixel(16'hFFFF, 6'd0, 6'd0);
    write_duration(16'd1);
    send_pixel(16'd0, 6'd31, 6'd31);
    send_pixel(16'd1, 6'd31, 6'd31);
    write_duration(16'hFFFF);
    send_pixel(16'hFFFE, 6'd0, 6'd0);
    send_pixel(16'd30000, 6'd5, 6'd60);
    random_pixels(150);
  endtask

  task automatic test_random_settings;
    write_duration(16'd2000);
    random_pixels(400);
    write_duration(16'($urandom_range(100, 5000)));
    random_pixels(300);
  endtask

  task automatic test_clean_stream;
    // no idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_duration(16'd1234);
    random_pixels(200);
    send_gap_pct = 15;
    recv_gap_pct = 15;
  endtask

  task automatic test_backpressure;
    // receiver holds off long enough that the pipe fills and in_ready drops
    write_duration(16'd3000);
    hold_cycles = 300;
    random_pixels(200);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_duration_extremes();
    test_random_settings();
    test_clean_stream();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
